// ===== rtl/arq_pkg.sv =====
// shared types, constants and codes of the ack and retransmit tracker
`default_nettype none

package arq_pkg;

	// table sizing and payload limit
	localparam int TABLE_DEPTH = 64;
	localparam int MAX_PAYLOAD = 100;

	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int ID_W   = 8;
	localparam int LEN_W  = 8;
	localparam int TIME_W = 32;
	localparam int TMO_W  = 16;
	localparam int KIND_W = 4;

	// configuration port
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;
	localparam int REG_IDX_W = ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_TIMEOUT = REG_IDX_W'(0);
	localparam logic [TMO_W-1:0] TIMEOUT_RST = TMO_W'(2);

	// operation codes
	localparam logic [1:0] FN_SEND = 2'd0;
	localparam logic [1:0] FN_ACK  = 2'd1;
	localparam logic [1:0] FN_DATA = 2'd2;
	localparam logic [1:0] FN_TICK = 2'd3;

	// result kinds
	localparam logic [KIND_W-1:0] K_SENT        = KIND_W'(0);
	localparam logic [KIND_W-1:0] K_TOO_LONG    = KIND_W'(1);
	localparam logic [KIND_W-1:0] K_SEND_FULL   = KIND_W'(2);
	localparam logic [KIND_W-1:0] K_ACK_MATCH   = KIND_W'(3);
	localparam logic [KIND_W-1:0] K_ACK_NOMATCH = KIND_W'(4);
	localparam logic [KIND_W-1:0] K_DUP_REACK   = KIND_W'(5);
	localparam logic [KIND_W-1:0] K_NEW_ACK     = KIND_W'(6);
	localparam logic [KIND_W-1:0] K_RETRANSMIT  = KIND_W'(7);
	localparam logic [KIND_W-1:0] K_NOTHING     = KIND_W'(8);

	typedef struct packed {
		logic [1:0]        func;
		logic [ID_W-1:0]   msg_id;
		logic [LEN_W-1:0]  msg_length;
		logic [TIME_W-1:0] now_seconds;
	} in_t;

	typedef struct packed {
		logic [KIND_W-1:0] result_kind;
		logic [ID_W-1:0]   result_id;
		logic              recv_full;
		logic              last;
	} out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEND,
		ST_ACK,
		ST_DATA,
		ST_TICK
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic send;
		logic ack;
		logic dscan;
		logic tscan;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic dup_hit;
		logic scan_done;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/arq_ack_retransmit_tracker.sv =====
// top level of the ack and retransmit tracker with its register port
`default_nettype none

// send and ack pass through their own state, then strobe their result from the result register;
// a data item scans the seen-id table, one entry a cycle, strobing on a duplicate or at scan end
// a tick scans the pending table the same way; each due id is strobed once the next one is
// found, the final one when the scan ends
// one transaction at a time, busy until its last result; a scan runs over the filled entries,
// up to a depth of 64, paced by the single read port of each table ram
// reset clears ids, counts, pending marks and the result strobe; timeout returns to 2

module arq_ack_retransmit_tracker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// transaction side
	input  wire logic                        start,
	output logic                             busy,
	input  wire arq_pkg::in_t                item,
	output arq_pkg::out_t                    result,
	output logic                             result_valid,
	// register port
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [arq_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [arq_pkg::DATA_W-1:0]  pwdata,
	output logic      [arq_pkg::DATA_W-1:0]  prdata,
	output logic                             pready
);

	arq_pkg::cmd_t cmd;
	arq_pkg::sts_t sts;

	logic [arq_pkg::TMO_W-1:0]     timeout_q;
	logic [arq_pkg::REG_IDX_W-1:0] reg_idx;
	logic                          wr_en;

	// register decode: word address, only the timeout register exists
	assign reg_idx = paddr[arq_pkg::ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= arq_pkg::TIMEOUT_RST;
		end else if (wr_en && (reg_idx == arq_pkg::REG_TIMEOUT)) begin
			timeout_q <= pwdata[arq_pkg::TMO_W-1:0];
		end
	end

	// reads of unused addresses return zero
	always_comb begin
		prdata = '0;
		if (reg_idx == arq_pkg::REG_TIMEOUT) begin
			prdata = {{(arq_pkg::DATA_W - arq_pkg::TMO_W){1'b0}}, timeout_q};
		end
	end

	// sequencing: picks the operation and holds it until its results are out
	arq_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.func  (item.func),
		.sts   (sts),
		.busy  (busy),
		.cmd   (cmd)
	);

	// tables, scan and result register
	arq_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.item        (item),
		.timeout     (timeout_q),
		.sts         (sts),
		.result      (result),
		.result_valid(result_valid)
	);

endmodule

`default_nettype wire

// ===== rtl/arq_ram.sv =====
// generic simple dual port ram with registered read
`default_nettype none

module arq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/arq_ctrl.sv =====
// sequencing state machine of the tracker
`default_nettype none

module arq_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [1:0]    func,
	input  wire arq_pkg::sts_t sts,
	output logic               busy,
	output arq_pkg::cmd_t      cmd
);

	arq_pkg::state_t state_q;
	arq_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= arq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			arq_pkg::ST_IDLE: begin
				if (start) begin
					case (func)
						arq_pkg::FN_SEND: state_d = arq_pkg::ST_SEND;
						arq_pkg::FN_ACK:  state_d = arq_pkg::ST_ACK;
						arq_pkg::FN_DATA: state_d = arq_pkg::ST_DATA;
						default:          state_d = arq_pkg::ST_TICK;
					endcase
				end
			end
			arq_pkg::ST_SEND: state_d = arq_pkg::ST_IDLE;
			arq_pkg::ST_ACK:  state_d = arq_pkg::ST_IDLE;
			arq_pkg::ST_DATA: begin
				if (sts.dup_hit || sts.scan_done) begin
					state_d = arq_pkg::ST_IDLE;
				end
			end
			arq_pkg::ST_TICK: begin
				if (sts.scan_done) begin
					state_d = arq_pkg::ST_IDLE;
				end
			end
			default: state_d = arq_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			arq_pkg::ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			arq_pkg::ST_SEND: cmd.send  = 1'b1;
			arq_pkg::ST_ACK:  cmd.ack   = 1'b1;
			arq_pkg::ST_DATA: cmd.dscan = 1'b1;
			arq_pkg::ST_TICK: cmd.tscan = 1'b1;
			default:          busy      = 1'b1;
		endcase
	end

`ifndef SYNTHESIS
	a_send_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == arq_pkg::ST_SEND |=> state_q == arq_pkg::ST_IDLE)
		else $error("send took more than one cycle");
	a_load_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> busy)
		else $error("accepted transaction did not make the block busy");
	a_tick_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == arq_pkg::ST_TICK && !sts.scan_done) |=> state_q == arq_pkg::ST_TICK)
		else $error("tick scan left early");
`endif

endmodule

`default_nettype wire

// ===== rtl/arq_dp.sv =====
// tables, scan counter and result register of the tracker
`default_nettype none

module arq_dp (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire arq_pkg::cmd_t              cmd,
	input  wire arq_pkg::in_t               item,
	input  wire logic [arq_pkg::TMO_W-1:0]  timeout,
	output arq_pkg::sts_t                   sts,
	output arq_pkg::out_t                   result,
	output logic                            result_valid
);

	localparam int IDX_W  = arq_pkg::IDX_W;
	localparam int CNT_W  = arq_pkg::CNT_W;
	localparam int ID_W   = arq_pkg::ID_W;
	localparam int TIME_W = arq_pkg::TIME_W;

	arq_pkg::in_t            item_q;
	logic [CNT_W-1:0]        nsid_q;
	logic [CNT_W-1:0]        seen_cnt_q;
	logic [arq_pkg::TABLE_DEPTH-1:0] pv_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    vld_s1;
	logic [IDX_W-1:0]        idx_s1;
	logic                    pv_s1;
	logic                    held_q;
	logic [IDX_W-1:0]        held_id_q;
	arq_pkg::out_t           res_q;
	logic                    res_vld_q;

	logic [CNT_W-1:0]        limit;
	logic                    issue;
	logic                    scan_done;
	logic                    dup_hit;
	logic                    due;
	logic [TIME_W-1:0]       age;
	logic [TIME_W-1:0]       pend_rdata;
	logic [ID_W-1:0]         seen_rdata;
	logic                    too_long;
	logic                    send_full;
	logic                    send_ok;
	logic                    ack_hit;
	logic                    seen_full;
	logic                    seen_we;
	logic [IDX_W-1:0]        id_idx;
	arq_pkg::out_t           res_d;
	logic                    fire;

	assign id_idx    = item_q.msg_id[IDX_W-1:0];
	assign too_long  = item_q.msg_length > arq_pkg::LEN_W'(arq_pkg::MAX_PAYLOAD);
	assign send_full = nsid_q >= CNT_W'(arq_pkg::TABLE_DEPTH);
	assign send_ok   = cmd.send && !too_long && !send_full;
	assign ack_hit   = (item_q.msg_id < ID_W'(arq_pkg::TABLE_DEPTH))
		&& (item_q.msg_id < ID_W'(nsid_q)) && pv_q[id_idx];
	assign seen_full = seen_cnt_q == CNT_W'(arq_pkg::TABLE_DEPTH);

	// scan over either table, one entry per cycle
	assign limit     = cmd.dscan ? seen_cnt_q : nsid_q;
	assign issue     = (cmd.dscan || cmd.tscan) && (cnt_q < limit);
	assign scan_done = !vld_s1 && !issue;
	assign dup_hit   = cmd.dscan && vld_s1 && (seen_rdata == item_q.msg_id);
	assign age       = item_q.now_seconds - pend_rdata;
	assign due       = cmd.tscan && vld_s1 && pv_s1 && (age > TIME_W'(timeout));
	assign seen_we   = cmd.dscan && !dup_hit && scan_done && !seen_full;

	assign sts.dup_hit   = dup_hit;
	assign sts.scan_done = scan_done;

	arq_ram #(
		.WIDTH(TIME_W),
		.DEPTH(arq_pkg::TABLE_DEPTH)
	) u_pend_ram (
		.clk  (clk),
		.we   (send_ok),
		.waddr(nsid_q[IDX_W-1:0]),
		.wdata(item_q.now_seconds),
		.raddr(cnt_q[IDX_W-1:0]),
		.rdata(pend_rdata)
	);

	arq_ram #(
		.WIDTH(ID_W),
		.DEPTH(arq_pkg::TABLE_DEPTH)
	) u_seen_ram (
		.clk  (clk),
		.we   (seen_we),
		.waddr(seen_cnt_q[IDX_W-1:0]),
		.wdata(item_q.msg_id),
		.raddr(cnt_q[IDX_W-1:0]),
		.rdata(seen_rdata)
	);

	// result selection
	always_comb begin
		fire  = 1'b0;
		res_d = '0;
		res_d.last = 1'b1;
		if (cmd.send) begin
			fire = 1'b1;
			if (too_long) begin
				res_d.result_kind = arq_pkg::K_TOO_LONG;
			end else if (send_full) begin
				res_d.result_kind = arq_pkg::K_SEND_FULL;
			end else begin
				res_d.result_kind = arq_pkg::K_SENT;
				res_d.result_id   = ID_W'(nsid_q);
			end
		end else if (cmd.ack) begin
			fire = 1'b1;
			res_d.result_kind = ack_hit ? arq_pkg::K_ACK_MATCH : arq_pkg::K_ACK_NOMATCH;
			res_d.result_id   = item_q.msg_id;
		end else if (cmd.dscan) begin
			res_d.result_id = item_q.msg_id;
			if (dup_hit) begin
				fire = 1'b1;
				res_d.result_kind = arq_pkg::K_DUP_REACK;
			end else if (scan_done) begin
				fire = 1'b1;
				res_d.result_kind = arq_pkg::K_NEW_ACK;
				res_d.recv_full   = seen_full;
			end
		end else if (cmd.tscan) begin
			// one due id is held back so the final one can carry last
			if (due && held_q) begin
				fire = 1'b1;
				res_d.result_kind = arq_pkg::K_RETRANSMIT;
				res_d.result_id   = ID_W'(held_id_q);
				res_d.last        = 1'b0;
			end else if (scan_done) begin
				fire = 1'b1;
				if (held_q) begin
					res_d.result_kind = arq_pkg::K_RETRANSMIT;
					res_d.result_id   = ID_W'(held_id_q);
				end else begin
					res_d.result_kind = arq_pkg::K_NOTHING;
				end
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nsid_q     <= '0;
			seen_cnt_q <= '0;
			pv_q       <= '0;
			cnt_q      <= '0;
			vld_s1     <= 1'b0;
			held_q     <= 1'b0;
			res_vld_q  <= 1'b0;
		end else begin
			res_vld_q <= fire;
			if (cmd.load) begin
				cnt_q  <= '0;
				vld_s1 <= 1'b0;
				held_q <= 1'b0;
			end else begin
				vld_s1 <= issue;
				if (issue) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				if (due) begin
					held_q <= 1'b1;
				end
			end
			if (send_ok) begin
				nsid_q <= nsid_q + CNT_W'(1);
				pv_q[nsid_q[IDX_W-1:0]] <= 1'b1;
			end
			if (cmd.ack && ack_hit) begin
				pv_q[id_idx] <= 1'b0;
			end
			if (seen_we) begin
				seen_cnt_q <= seen_cnt_q + CNT_W'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= item;
		end
		idx_s1 <= cnt_q[IDX_W-1:0];
		pv_s1  <= pv_q[cnt_q[IDX_W-1:0]];
		if (due) begin
			held_id_q <= idx_s1;
		end
		if (fire) begin
			res_q <= res_d;
		end
	end

	assign result       = res_q;
	assign result_valid = res_vld_q;

`ifndef SYNTHESIS
	a_nsid_bound: assert property (@(posedge clk) disable iff (!arst_n)
		nsid_q <= CNT_W'(arq_pkg::TABLE_DEPTH))
		else $error("send id ran past table depth");
	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_cnt_q <= CNT_W'(arq_pkg::TABLE_DEPTH))
		else $error("seen count ran past table depth");
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.dscan || cmd.tscan) |-> cnt_q <= limit)
		else $error("scan counter ran past its limit");
	a_no_fire_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!cmd.send && !cmd.ack && !cmd.dscan && !cmd.tscan) |=> !result_valid)
		else $error("result strobe without work");
`endif

endmodule

`default_nettype wire
